// ===== rtl/core/rgbpool_pkg.sv =====
`timescale 1ns / 1ps
// rgbpool_pkg: shared widths, register indexes and types of the pooling unit
package rgbpool_pkg;

  localparam int PIX_W      = 8;
  localparam int IDX_W      = 9;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 12;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic MODE_AVG = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_POOL_MODE    = 2'd2
  } cfg_reg_t;

  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    acc_t red;
    acc_t green;
    acc_t blue;
  } acc_rgb_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } pix_rgb_t;

  typedef struct packed {
    acc_rgb_t             acc;
    logic                 mode;
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/core/rgb_pool_3x3_avg_max_unit.sv =====
`timescale 1ns / 1ps
// rgb_pool_3x3_avg_max_unit: non-overlapping window pooling of an rgb pixel stream
//
// Takes one pixel per clock in raster order unless stalled, a rate set by the column
// accumulator memory: each pixel does one read-modify-write of its window column's
// entry, with the write of the previous pixel forwarded into the next one. It returns
// one pooled pixel per whole KERNEL x KERNEL window after its bottom-right pixel passes
// the accumulate stage. A four-entry result queue sits in front of the output, so
// downstream stalls are absorbed for a few windows before pixel_stall rises. The
// accumulator memory needs no clearing after reset: the first pixel of each window
// loads its entry. Configuration is taken on cfg_valid at any time out of reset.
module rgb_pool_3x3_avg_max_unit #(
  parameter int KERNEL   = 3,
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbpool_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbpool_pkg::CFG_W-1:0]     cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [rgbpool_pkg::PIX_W-1:0]     pixel_red,
  input  logic [rgbpool_pkg::PIX_W-1:0]     pixel_green,
  input  logic [rgbpool_pkg::PIX_W-1:0]     pixel_blue,
  input  logic                              start_of_frame,
  output logic                              pooled_valid,
  input  logic                              pooled_stall,
  output logic [rgbpool_pkg::PIX_W-1:0]     pooled_red,
  output logic [rgbpool_pkg::PIX_W-1:0]     pooled_green,
  output logic [rgbpool_pkg::PIX_W-1:0]     pooled_blue,
  output logic [rgbpool_pkg::IDX_W-1:0]     pooled_row,
  output logic [rgbpool_pkg::IDX_W-1:0]     pooled_col,
  output logic                              last_of_frame
);
  import rgbpool_pkg::*;

  localparam int ACC_DEPTH = MAX_COLS / KERNEL;
  localparam int AW        = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int WC_W      = $clog2(ACC_DEPTH + 1);
  localparam int WR_W      = $clog2(MAX_ROWS / KERNEL + 1);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int PH_W      = $clog2(KERNEL);
  localparam int MAXD      = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DIM_W     = (($clog2(MAXD + 1) > CFG_W) ? $clog2(MAXD + 1) : CFG_W) + 1;
  localparam int KK        = KERNEL * KERNEL;
  localparam int DIV_S     = ACC_W + $clog2(KK);
  localparam int PROD_W    = 2 * ACC_W + 1;
  localparam logic [ACC_W:0] DIV_M = (ACC_W + 1)'(((2 ** DIV_S) + KK - 1) / KK);

  localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(KERNEL - 1);
  localparam logic [DIM_W-1:0] DIM_K    = DIM_W'(KERNEL);
  localparam logic [DIM_W-1:0] DIM_2K   = DIM_W'(2 * KERNEL);
  localparam logic [DIM_W-1:0] DIM_COLS = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] DIM_ROWS = DIM_W'(MAX_ROWS);

  // saturating average or max of one channel
  function automatic pix_t pool_out(input acc_t v, input logic mode);
    logic [PROD_W-1:0] prod;
    acc_t              val;
    begin
      prod = PROD_W'(v) * PROD_W'(DIV_M);
      val  = (mode == MODE_AVG) ? acc_t'(prod >> DIV_S) : v;
      pool_out = (val > acc_t'(255)) ? pix_t'(255) : pix_t'(val);
    end
  endfunction

  // configuration
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             pool_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1024);
      image_height <= CFG_W'(1024);
      pool_mode    <= MODE_AVG;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_POOL_MODE:    pool_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = !rst;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  assign w_eff = (image_width == '0) ? DIM_W'(1) :
                 ((DIM_W'(image_width) > DIM_COLS) ? DIM_COLS : DIM_W'(image_width));
  assign h_eff = (image_height == '0) ? DIM_W'(1) :
                 ((DIM_W'(image_height) > DIM_ROWS) ? DIM_ROWS : DIM_W'(image_height));

  // position counters
  logic [COL_W-1:0] col, col_next, c_col;
  logic [COL_W-1:0] col_base, col_base_next, c_col_base;
  logic [PH_W-1:0]  col_phase, col_phase_next, c_col_phase;
  logic [WC_W-1:0]  win_col, win_col_next, c_win_col;
  logic [ROW_W-1:0] row, row_next, c_row;
  logic [ROW_W-1:0] row_base, row_base_next, c_row_base;
  logic [PH_W-1:0]  row_phase, row_phase_next, c_row_phase;
  logic [WR_W-1:0]  win_row, win_row_next, c_win_row;

  logic accept;
  logic restart;
  logic win_ok;
  logic win_first;
  logic win_final;
  logic win_last;
  logic [AW-1:0] rd_addr;

  assign accept = pixel_valid && !pixel_stall;

  always_comb begin
    restart = start_of_frame || (DIM_W'(col) >= w_eff) || (DIM_W'(row) >= h_eff);
    c_col       = restart ? '0 : col;
    c_col_base  = restart ? '0 : col_base;
    c_col_phase = restart ? '0 : col_phase;
    c_win_col   = restart ? '0 : win_col;
    c_row       = restart ? '0 : row;
    c_row_base  = restart ? '0 : row_base;
    c_row_phase = restart ? '0 : row_phase;
    c_win_row   = restart ? '0 : win_row;

    win_ok    = (DIM_W'(c_col_base) + DIM_K <= w_eff) && (DIM_W'(c_row_base) + DIM_K <= h_eff);
    win_first = (c_col_phase == '0) && (c_row_phase == '0);
    win_final = (c_col_phase == PH_LAST) && (c_row_phase == PH_LAST);
    win_last  = (DIM_W'(c_col_base) + DIM_2K > w_eff) && (DIM_W'(c_row_base) + DIM_2K > h_eff);
    rd_addr   = c_win_col[AW-1:0];

    col_next       = c_col + COL_W'(1);
    col_base_next  = c_col_base;
    col_phase_next = c_col_phase + PH_W'(1);
    win_col_next   = c_win_col;
    row_next       = c_row;
    row_base_next  = c_row_base;
    row_phase_next = c_row_phase;
    win_row_next   = c_win_row;
    if (c_col_phase == PH_LAST) begin
      col_phase_next = '0;
      col_base_next  = c_col_base + COL_W'(KERNEL);
      win_col_next   = c_win_col + WC_W'(1);
    end
    if (DIM_W'(c_col) + DIM_W'(1) >= w_eff) begin
      col_next       = '0;
      col_base_next  = '0;
      col_phase_next = '0;
      win_col_next   = '0;
      if (DIM_W'(c_row) + DIM_W'(1) >= h_eff) begin
        row_next       = '0;
        row_base_next  = '0;
        row_phase_next = '0;
        win_row_next   = '0;
      end else begin
        row_next = c_row + ROW_W'(1);
        if (c_row_phase == PH_LAST) begin
          row_phase_next = '0;
          row_base_next  = c_row_base + ROW_W'(KERNEL);
          win_row_next   = c_win_row + WR_W'(1);
        end else begin
          row_phase_next = c_row_phase + PH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      col_base  <= '0;
      col_phase <= '0;
      win_col   <= '0;
      row       <= '0;
      row_base  <= '0;
      row_phase <= '0;
      win_row   <= '0;
    end else if (accept) begin
      col       <= col_next;
      col_base  <= col_base_next;
      col_phase <= col_phase_next;
      win_col   <= win_col_next;
      row       <= row_next;
      row_base  <= row_base_next;
      row_phase <= row_phase_next;
      win_row   <= win_row_next;
    end
  end

  // accumulate stage
  logic             s1_valid;
  logic             s1_write;
  logic             s1_emit;
  logic             s1_first;
  logic             s1_mode;
  logic             s1_fwd;
  logic             s1_last;
  logic [AW-1:0]    s1_addr;
  logic [IDX_W-1:0] s1_row;
  logic [IDX_W-1:0] s1_col;
  pix_rgb_t         s1_px;
  acc_rgb_t         rdata;
  acc_rgb_t         fwd_data;
  acc_rgb_t         acc_old;
  acc_rgb_t         acc_new;

  acc_rgb_t acc_mem [ACC_DEPTH];

  always_ff @(posedge clk) begin
    if (s1_valid && s1_write) begin
      acc_mem[s1_addr] <= acc_new;
    end
    if (accept && win_ok) begin
      rdata <= acc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_write <= win_ok;
      s1_emit  <= win_ok && win_final;
      s1_first <= win_first;
      s1_mode  <= pool_mode;
      s1_fwd   <= s1_valid && s1_write && (s1_addr == rd_addr);
      s1_last  <= win_last;
      s1_addr  <= rd_addr;
      s1_row   <= IDX_W'(c_win_row);
      s1_col   <= IDX_W'(c_win_col);
      s1_px    <= '{red: pixel_red, green: pixel_green, blue: pixel_blue};
      fwd_data <= acc_new;
    end
  end

  always_comb begin
    acc_old = s1_fwd ? fwd_data : rdata;
    if (s1_first) begin
      acc_new = '{red: acc_t'(s1_px.red), green: acc_t'(s1_px.green),
                  blue: acc_t'(s1_px.blue)};
    end else if (s1_mode == MODE_MAX) begin
      acc_new.red   = (acc_t'(s1_px.red) > acc_old.red) ? acc_t'(s1_px.red) : acc_old.red;
      acc_new.green = (acc_t'(s1_px.green) > acc_old.green) ? acc_t'(s1_px.green)
                                                            : acc_old.green;
      acc_new.blue  = (acc_t'(s1_px.blue) > acc_old.blue) ? acc_t'(s1_px.blue) : acc_old.blue;
    end else begin
      acc_new.red   = acc_old.red + acc_t'(s1_px.red);
      acc_new.green = acc_old.green + acc_t'(s1_px.green);
      acc_new.blue  = acc_old.blue + acc_t'(s1_px.blue);
    end
  end

  // result queue
  result_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 push;
  logic                 pop;
  result_t              head;

  assign push = s1_valid && s1_emit;
  assign pop  = pooled_valid && !pooled_stall;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{acc: acc_new, mode: s1_mode, row: s1_row, col: s1_col,
                            last: s1_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  // room is kept for the request in the accumulate stage and the one being accepted
  assign pixel_stall = rst || ((count + FIFO_CW'(push)) > FIFO_CW'(FIFO_DEPTH - 1));

  assign pooled_valid  = (count != '0);
  assign pooled_red    = pool_out(head.acc.red, head.mode);
  assign pooled_green  = pool_out(head.acc.green, head.mode);
  assign pooled_blue   = pool_out(head.acc.blue, head.mode);
  assign pooled_row    = head.row;
  assign pooled_col    = head.col;
  assign last_of_frame = head.last;

endmodule

// ===== rtl/core/rgbpool_checker.sv =====
`timescale 1ns / 1ps
// rgbpool_checker: port-level assertions of the pooling unit and their binding
module rgbpool_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          pixel_valid,
  input logic                          pixel_stall,
  input logic                          pooled_valid,
  input logic                          pooled_stall,
  input logic [rgbpool_pkg::PIX_W-1:0] pooled_red,
  input logic [rgbpool_pkg::PIX_W-1:0] pooled_green,
  input logic [rgbpool_pkg::PIX_W-1:0] pooled_blue,
  input logic [rgbpool_pkg::IDX_W-1:0] pooled_row,
  input logic [rgbpool_pkg::IDX_W-1:0] pooled_col,
  input logic                          last_of_frame
);

  // queue empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !pooled_valid)
    else $error("pooled request pending after reset");

  // a fresh result needs an earlier accepted pixel that passed the accumulate stage
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(pooled_valid) |-> $past(pixel_valid && !pixel_stall, 2))
    else $error("pooled request without a preceding pixel");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    pooled_valid && pooled_stall |=> pooled_valid &&
      $stable({pooled_red, pooled_green, pooled_blue, pooled_row, pooled_col, last_of_frame}))
    else $error("stalled pooled request changed");

endmodule

bind rgb_pool_3x3_avg_max_unit rgbpool_checker u_rgbpool_checker (.*);
